// ===== src/jstgibbs_pkg.sv =====
// package: sizes, command codes and shared types of the sentiment-topic sampler
package jstgibbs_pkg;

   localparam int LABELS = 3;
   localparam int TOPICS = 64;
   localparam int VOCAB  = 4096;
   localparam int DOCS   = 1024;
   localparam int LT     = LABELS * TOPICS;

   localparam int CMD_W   = 3;
   localparam int DOC_W   = 10;
   localparam int WORD_W  = 12;
   localparam int LABEL_W = 2;
   localparam int TOPIC_W = 6;
   localparam int LK_W    = LABEL_W + TOPIC_W;
   localparam int PRIOR_W = 24;
   localparam int UNI_W   = 16;
   localparam int FRAC_W  = 16;

   localparam int CNTL_W = 20;
   localparam int CNTS_W = 16;
   localparam int WPS_W  = 36;
   localparam int TPS_W  = 32;
   localparam int RW_W   = 32;

   localparam int Q_FRAC  = 24;
   localparam int Q_W     = Q_FRAC + 1;
   localparam int DIV_W   = 38;
   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = Q_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   localparam int LTW_DEPTH = LT * VOCAB;
   localparam int LTW_AW    = LK_W + WORD_W;
   localparam int DLT_DEPTH = DOCS * LT;
   localparam int DLT_AW    = 18;
   localparam int DL_DEPTH  = DOCS * LABELS;
   localparam int DL_AW     = 12;

   localparam logic [CMD_W-1:0] CMD_WORD_PRIOR  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_TOPIC_PRIOR = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ADD_TOKEN   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SAMPLE      = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd4;

   localparam logic [PRIOR_W-1:0] DOC_PRIOR_RESET = 24'd65536;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] num;
      logic [DIV_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic           done;
      logic [Q_W-1:0] quot;
   } div_rsp_type;

endpackage

// ===== src/jstgibbs_if.sv =====
// interfaces: request, response and configuration channels

interface jstgibbs_req_if;
   logic                                valid;
   logic                                ready;
   logic [jstgibbs_pkg::CMD_W-1:0]      command;
   logic [jstgibbs_pkg::DOC_W-1:0]      doc_index;
   logic [jstgibbs_pkg::WORD_W-1:0]     word_id;
   logic [jstgibbs_pkg::LABEL_W-1:0]    label_in;
   logic [jstgibbs_pkg::TOPIC_W-1:0]    topic_in;
   logic [jstgibbs_pkg::PRIOR_W-1:0]    prior_value;
   logic [jstgibbs_pkg::UNI_W-1:0]      uniform;
   modport source (output valid, command, doc_index, word_id, label_in, topic_in,
                   prior_value, uniform, input ready);
   modport sink (input valid, command, doc_index, word_id, label_in, topic_in,
                 prior_value, uniform, output ready);
endinterface

interface jstgibbs_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [jstgibbs_pkg::LABEL_W-1:0]    new_label;
   logic [jstgibbs_pkg::TOPIC_W-1:0]    new_topic;
   logic                                status;
   modport source (output valid, new_label, new_topic, status, input ready);
   modport sink (input valid, new_label, new_topic, status, output ready);
endinterface

interface jstgibbs_csr_if;
   logic                                valid;
   logic                                ready;
   logic [jstgibbs_pkg::PRIOR_W-1:0]    doc_sentiment_prior;
   modport source (output valid, doc_sentiment_prior, input ready);
   modport sink (input valid, doc_sentiment_prior, output ready);
endinterface

// ===== src/joint_sentiment_topic_gibbs_sampler.sv =====
// top level: count tables, priors and sampling sequencer of the sentiment-topic sampler
//
// req_chan carries one command item (write word prior, write topic prior, add token,
// sample token, clear counts); rsp_chan returns exactly one result item per command.
// csr_chan writes the document sentiment prior; it is always ready, write only when idle.
// The block takes one item at a time: req_chan.ready is high only while the sequencer idles.
// Prior writes and add token read the tables and then write them; clear counts writes one
// table row per cycle; sample token uses the shared two-bit-per-cycle divider (two
// divides per label-topic weight, one more per label) and then searches the running
// sums entry by entry, with a read and a compare for each entry.
// After reset the block sweeps all count and prior tables to zero with req_chan.ready low.
// The result sits in an output register; a new item is taken while it waits, and the
// block holds its next result until rsp_chan.ready takes the old one.
module joint_sentiment_topic_gibbs_sampler (
   input  logic           clock,
   input  logic           reset,
   jstgibbs_req_if.sink   req_chan,
   jstgibbs_rsp_if.source rsp_chan,
   jstgibbs_csr_if.sink   csr_chan
);
   localparam int SW = 5;
   localparam logic [SW-1:0] ST_INIT     = 5'd0;
   localparam logic [SW-1:0] ST_IDLE     = 5'd1;
   localparam logic [SW-1:0] ST_WP_RD    = 5'd2;
   localparam logic [SW-1:0] ST_WP_WR    = 5'd3;
   localparam logic [SW-1:0] ST_TP_RD    = 5'd4;
   localparam logic [SW-1:0] ST_TP_WR    = 5'd5;
   localparam logic [SW-1:0] ST_CNT_RD   = 5'd6;
   localparam logic [SW-1:0] ST_CNT_WR   = 5'd7;
   localparam logic [SW-1:0] ST_LBL_RD   = 5'd8;
   localparam logic [SW-1:0] ST_R3       = 5'd9;
   localparam logic [SW-1:0] ST_R3_W     = 5'd10;
   localparam logic [SW-1:0] ST_TOP_RD   = 5'd11;
   localparam logic [SW-1:0] ST_R1       = 5'd12;
   localparam logic [SW-1:0] ST_R1_W     = 5'd13;
   localparam logic [SW-1:0] ST_R2       = 5'd14;
   localparam logic [SW-1:0] ST_R2_W     = 5'd15;
   localparam logic [SW-1:0] ST_MUL1     = 5'd16;
   localparam logic [SW-1:0] ST_MUL2     = 5'd17;
   localparam logic [SW-1:0] ST_ACC      = 5'd18;
   localparam logic [SW-1:0] ST_U        = 5'd19;
   localparam logic [SW-1:0] ST_U2       = 5'd20;
   localparam logic [SW-1:0] ST_SCAN_RD  = 5'd21;
   localparam logic [SW-1:0] ST_SCAN_CMP = 5'd22;
   localparam logic [SW-1:0] ST_CLR      = 5'd23;
   localparam logic [SW-1:0] ST_DONE     = 5'd24;

   localparam int LW  = jstgibbs_pkg::LABEL_W;
   localparam int TW  = jstgibbs_pkg::TOPIC_W;
   localparam int KW  = jstgibbs_pkg::LK_W;
   localparam int DW  = jstgibbs_pkg::DIV_W;
   localparam int QW  = jstgibbs_pkg::Q_W;
   localparam int FW  = jstgibbs_pkg::FRAC_W;
   localparam int CLW = jstgibbs_pkg::CNTL_W;
   localparam int CSW = jstgibbs_pkg::CNTS_W;
   localparam int AW  = jstgibbs_pkg::LTW_AW;
   localparam int RWW = jstgibbs_pkg::RW_W;
   localparam int PW  = jstgibbs_pkg::PRIOR_W;

   // memories
   logic [CLW-1:0]                     ltw_mem [jstgibbs_pkg::LTW_DEPTH];
   logic [PW-1:0]                      wp_mem  [jstgibbs_pkg::LTW_DEPTH];
   logic [CLW-1:0]                     lt_mem  [jstgibbs_pkg::LT];
   logic [jstgibbs_pkg::WPS_W-1:0]     wps_mem [jstgibbs_pkg::LT];
   logic [PW-1:0]                      tp_mem  [jstgibbs_pkg::LT];
   logic [RWW-1:0]                     rw_mem  [jstgibbs_pkg::LT];
   logic [CSW-1:0]                     dlt_mem [jstgibbs_pkg::DLT_DEPTH];
   logic [CSW-1:0]                     dl_mem  [jstgibbs_pkg::DL_DEPTH];
   logic [CSW-1:0]                     doc_mem [jstgibbs_pkg::DOCS];

   logic [CLW-1:0]                 ltw_rd_ff, lt_rd_ff;
   logic [PW-1:0]                  wp_rd_ff, tp_rd_ff;
   logic [jstgibbs_pkg::WPS_W-1:0] wps_rd_ff;
   logic [RWW-1:0]                 rw_rd_ff;
   logic [CSW-1:0]                 dlt_rd_ff, dl_rd_ff, doc_rd_ff;

   // sequencer and item registers
   logic [SW-1:0]                    state_ff, state_in;
   logic [jstgibbs_pkg::CMD_W-1:0]   cmd_ff, cmd_in;
   logic [jstgibbs_pkg::DOC_W-1:0]   d_ff, d_in;
   logic [jstgibbs_pkg::WORD_W-1:0]  w_ff, w_in;
   logic [PW-1:0]                    pv_ff, pv_in;
   logic [jstgibbs_pkg::UNI_W-1:0]   uni_ff, uni_in;
   logic [LW-1:0]                    cl_ff, cl_in, a_ff, a_in;
   logic [TW-1:0]                    ck_ff, ck_in, b_ff, b_in;
   logic                             add_ff, add_in, flag_ff, flag_in;
   logic [AW-1:0]                    clr_cnt_ff, clr_cnt_in;
   logic [PW-1:0]                    g_ff, g_in;
   logic [jstgibbs_pkg::TPS_W-1:0]   tps_ff [jstgibbs_pkg::LABELS];
   logic [jstgibbs_pkg::TPS_W-1:0]   tps_in [jstgibbs_pkg::LABELS];
   logic [RWW-1:0]                   acc_ff, acc_in, u_ff, u_in;
   logic [CSW-1:0]                   ndl_ff, ndl_in;
   logic [QW-1:0]                    r1_ff, r1_in, r2_ff, r2_in, r3_ff, r3_in;
   logic [DW-1:0]                    r2num_ff, r2num_in, r2den_ff, r2den_in;
   logic [jstgibbs_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0]                    rsp_label_ff, rsp_label_in;
   logic [TW-1:0]                    rsp_topic_ff, rsp_topic_in;
   logic                             rsp_status_ff, rsp_status_in;

   // datapath
   logic                             use_ab, clr_any, clr_prior;
   logic [KW-1:0]                    rlk, wlk, loop_lk;
   logic [LW-1:0]                    rl;
   logic [AW-1:0]                    ltw_ra, ltw_wa;
   logic [jstgibbs_pkg::DLT_AW-1:0]  dlt_ra, dlt_wa;
   logic [jstgibbs_pkg::DL_AW-1:0]   dl_ra, dl_wa;
   logic                             ltw_we, wp_we, lt_we, wps_we, tp_we, dlt_we, dl_we;
   logic                             doc_we, rw_we;
   logic [CLW-1:0]                   ltw_new, lt_new;
   logic [CSW-1:0]                   dlt_new, dl_new, doc_new;
   logic [jstgibbs_pkg::WPS_W-1:0]   wps_new;
   logic                             cnt_flag;
   logic [jstgibbs_pkg::MUL_A_W-1:0] mul_a;
   logic [jstgibbs_pkg::MUL_B_W-1:0] mul_b;
   logic [QW-1:0]                    wt;
   logic [RWW:0]                     acc_sum;
   logic                             lk_ok, w_ok, d_ok;
   jstgibbs_pkg::div_req_type        div_req;
   jstgibbs_pkg::div_rsp_type        div_rsp;

   jstgibbs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign csr_chan.ready     = 1'b1;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.new_label = rsp_label_ff;
   assign rsp_chan.new_topic = rsp_topic_ff;
   assign rsp_chan.status    = rsp_status_ff;

   // table addressing
   always_comb begin
      use_ab    = (state_ff == ST_LBL_RD) || (state_ff == ST_TOP_RD) ||
                  (state_ff == ST_SCAN_RD);
      clr_prior = (state_ff == ST_INIT);
      clr_any   = clr_prior || (state_ff == ST_CLR);
      loop_lk   = {a_ff, b_ff};
      wlk       = {cl_ff, ck_ff};
      rlk       = use_ab ? loop_lk : wlk;
      rl        = use_ab ? a_ff : cl_ff;
      ltw_ra    = {rlk, w_ff};
      dlt_ra    = jstgibbs_pkg::DLT_AW'(d_ff) * jstgibbs_pkg::DLT_AW'(jstgibbs_pkg::LT) +
                  jstgibbs_pkg::DLT_AW'(rlk);
      dl_ra     = jstgibbs_pkg::DL_AW'(d_ff) * jstgibbs_pkg::DL_AW'(jstgibbs_pkg::LABELS) +
                  jstgibbs_pkg::DL_AW'(rl);
      ltw_wa    = clr_any ? clr_cnt_ff : {wlk, w_ff};
      dlt_wa    = clr_any ? clr_cnt_ff[jstgibbs_pkg::DLT_AW-1:0] :
                  jstgibbs_pkg::DLT_AW'(d_ff) * jstgibbs_pkg::DLT_AW'(jstgibbs_pkg::LT) +
                  jstgibbs_pkg::DLT_AW'(wlk);
      dl_wa     = clr_any ? clr_cnt_ff[jstgibbs_pkg::DL_AW-1:0] :
                  jstgibbs_pkg::DL_AW'(d_ff) * jstgibbs_pkg::DL_AW'(jstgibbs_pkg::LABELS) +
                  jstgibbs_pkg::DL_AW'(cl_ff);
      ltw_we    = clr_any || (state_ff == ST_CNT_WR);
      wp_we     = clr_prior || (state_ff == ST_WP_WR);
      lt_we     = (clr_any && (clr_cnt_ff < AW'(jstgibbs_pkg::LT))) || (state_ff == ST_CNT_WR);
      wps_we    = (clr_prior && (clr_cnt_ff < AW'(jstgibbs_pkg::LT))) ||
                  (state_ff == ST_WP_WR);
      tp_we     = (clr_prior && (clr_cnt_ff < AW'(jstgibbs_pkg::LT))) ||
                  (state_ff == ST_TP_WR);
      dlt_we    = (clr_any && (clr_cnt_ff < AW'(jstgibbs_pkg::DLT_DEPTH))) ||
                  (state_ff == ST_CNT_WR);
      dl_we     = (clr_any && (clr_cnt_ff < AW'(jstgibbs_pkg::DL_DEPTH))) ||
                  (state_ff == ST_CNT_WR);
      doc_we    = (clr_any && (clr_cnt_ff < AW'(jstgibbs_pkg::DOCS))) ||
                  (state_ff == ST_CNT_WR);
      rw_we     = (state_ff == ST_ACC);
   end

   // saturating count update
   always_comb begin
      cnt_flag = 1'b0;
      if (add_ff) begin
         ltw_new = (ltw_rd_ff == '1) ? ltw_rd_ff : ltw_rd_ff + CLW'(1);
         lt_new  = (lt_rd_ff == '1) ? lt_rd_ff : lt_rd_ff + CLW'(1);
         dlt_new = (dlt_rd_ff == '1) ? dlt_rd_ff : dlt_rd_ff + CSW'(1);
         dl_new  = (dl_rd_ff == '1) ? dl_rd_ff : dl_rd_ff + CSW'(1);
         doc_new = (doc_rd_ff == '1) ? doc_rd_ff : doc_rd_ff + CSW'(1);
         cnt_flag = (ltw_rd_ff == '1) || (lt_rd_ff == '1) || (dlt_rd_ff == '1) ||
                    (dl_rd_ff == '1) || (doc_rd_ff == '1);
      end else begin
         ltw_new = (ltw_rd_ff == '0) ? ltw_rd_ff : ltw_rd_ff - CLW'(1);
         lt_new  = (lt_rd_ff == '0) ? lt_rd_ff : lt_rd_ff - CLW'(1);
         dlt_new = (dlt_rd_ff == '0) ? dlt_rd_ff : dlt_rd_ff - CSW'(1);
         dl_new  = (dl_rd_ff == '0) ? dl_rd_ff : dl_rd_ff - CSW'(1);
         doc_new = (doc_rd_ff == '0) ? doc_rd_ff : doc_rd_ff - CSW'(1);
         cnt_flag = (ltw_rd_ff == '0) || (lt_rd_ff == '0) || (dlt_rd_ff == '0) ||
                    (dl_rd_ff == '0) || (doc_rd_ff == '0);
      end
      wps_new = wps_rd_ff - jstgibbs_pkg::WPS_W'(wp_rd_ff) + jstgibbs_pkg::WPS_W'(pv_ff);
   end

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (ltw_we) begin
         ltw_mem[ltw_wa] <= clr_any ? '0 : ltw_new;
      end
      ltw_rd_ff <= ltw_mem[ltw_ra];
   end

   always_ff @(posedge clock) begin
      if (wp_we) begin
         wp_mem[ltw_wa] <= clr_prior ? '0 : pv_ff;
      end
      wp_rd_ff <= wp_mem[ltw_ra];
   end

   always_ff @(posedge clock) begin
      if (lt_we) begin
         lt_mem[clr_any ? clr_cnt_ff[KW-1:0] : wlk] <= clr_any ? '0 : lt_new;
      end
      lt_rd_ff <= lt_mem[rlk];
   end

   always_ff @(posedge clock) begin
      if (wps_we) begin
         wps_mem[clr_prior ? clr_cnt_ff[KW-1:0] : wlk] <= clr_prior ? '0 : wps_new;
      end
      wps_rd_ff <= wps_mem[rlk];
   end

   always_ff @(posedge clock) begin
      if (tp_we) begin
         tp_mem[clr_prior ? clr_cnt_ff[KW-1:0] : wlk] <= clr_prior ? '0 : pv_ff;
      end
      tp_rd_ff <= tp_mem[rlk];
   end

   always_ff @(posedge clock) begin
      if (rw_we) begin
         rw_mem[loop_lk] <= acc_in;
      end
      rw_rd_ff <= rw_mem[loop_lk];
   end

   always_ff @(posedge clock) begin
      if (dlt_we) begin
         dlt_mem[dlt_wa] <= clr_any ? '0 : dlt_new;
      end
      dlt_rd_ff <= dlt_mem[dlt_ra];
   end

   always_ff @(posedge clock) begin
      if (dl_we) begin
         dl_mem[dl_wa] <= clr_any ? '0 : dl_new;
      end
      dl_rd_ff <= dl_mem[dl_ra];
   end

   always_ff @(posedge clock) begin
      if (doc_we) begin
         doc_mem[clr_any ? clr_cnt_ff[jstgibbs_pkg::DOC_W-1:0] : d_ff] <=
            clr_any ? '0 : doc_new;
      end
      doc_rd_ff <= doc_mem[d_ff];
   end

   // shared multiplier and divider operands
   always_comb begin
      unique case (state_ff)
         ST_MUL1: begin
            mul_a = jstgibbs_pkg::MUL_A_W'(r1_ff);
            mul_b = r2_ff;
         end
         ST_MUL2: begin
            mul_a = jstgibbs_pkg::MUL_A_W'(prod_ff[jstgibbs_pkg::Q_FRAC +: QW]);
            mul_b = r3_ff;
         end
         default: begin
            mul_a = acc_ff;
            mul_b = jstgibbs_pkg::MUL_B_W'(uni_ff);
         end
      endcase
      prod_in = mul_a * mul_b;
      wt      = prod_ff[jstgibbs_pkg::Q_FRAC +: QW];
      acc_sum = {1'b0, acc_ff} + (RWW + 1)'(wt);

      div_req.start = (state_ff == ST_R3) || (state_ff == ST_R1) || (state_ff == ST_R2);
      unique case (state_ff)
         ST_R3: begin
            div_req.num = DW'({dl_rd_ff, {FW{1'b0}}}) + DW'(g_ff);
            div_req.den = DW'({doc_rd_ff, {FW{1'b0}}}) +
                          DW'(g_ff) * DW'(jstgibbs_pkg::LABELS);
         end
         ST_R1: begin
            div_req.num = DW'({ltw_rd_ff, {FW{1'b0}}}) + DW'(wp_rd_ff);
            div_req.den = DW'({lt_rd_ff, {FW{1'b0}}}) + DW'(wps_rd_ff);
         end
         default: begin
            div_req.num = r2num_ff;
            div_req.den = r2den_ff;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      d_in          = d_ff;
      w_in          = w_ff;
      pv_in         = pv_ff;
      uni_in        = uni_ff;
      cl_in         = cl_ff;
      ck_in         = ck_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      add_in        = add_ff;
      flag_in       = flag_ff;
      clr_cnt_in    = clr_cnt_ff;
      g_in          = csr_chan.valid ? csr_chan.doc_sentiment_prior : g_ff;
      tps_in        = tps_ff;
      acc_in        = acc_ff;
      u_in          = u_ff;
      ndl_in        = ndl_ff;
      r1_in         = r1_ff;
      r2_in         = r2_ff;
      r3_in         = r3_ff;
      r2num_in      = r2num_ff;
      r2den_in      = r2den_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_label_in  = rsp_label_ff;
      rsp_topic_in  = rsp_topic_ff;
      rsp_status_in = rsp_status_ff;
      lk_ok = (32'(req_chan.label_in) < jstgibbs_pkg::LABELS) &&
              (32'(req_chan.topic_in) < jstgibbs_pkg::TOPICS);
      w_ok  = (32'(req_chan.word_id) < jstgibbs_pkg::VOCAB);
      d_ok  = (32'(req_chan.doc_index) < jstgibbs_pkg::DOCS);

      unique case (state_ff)
         ST_INIT, ST_CLR: begin
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(jstgibbs_pkg::LTW_DEPTH - 1)) begin
               clr_cnt_in = '0;
               state_in   = (state_ff == ST_INIT) ? ST_IDLE : ST_DONE;
            end
         end
         ST_IDLE: begin
            if (req_chan.valid) begin
               cmd_in  = req_chan.command;
               d_in    = req_chan.doc_index;
               w_in    = req_chan.word_id;
               pv_in   = req_chan.prior_value;
               uni_in  = req_chan.uniform;
               cl_in   = req_chan.label_in;
               ck_in   = req_chan.topic_in;
               flag_in = 1'b0;
               state_in = ST_DONE;
               case (req_chan.command)
                  jstgibbs_pkg::CMD_WORD_PRIOR: begin
                     if (lk_ok && w_ok) begin
                        state_in = ST_WP_RD;
                     end
                  end
                  jstgibbs_pkg::CMD_TOPIC_PRIOR: begin
                     if (lk_ok) begin
                        state_in = ST_TP_RD;
                     end
                  end
                  jstgibbs_pkg::CMD_ADD_TOKEN, jstgibbs_pkg::CMD_SAMPLE: begin
                     if (lk_ok && w_ok && d_ok) begin
                        add_in   = (req_chan.command == jstgibbs_pkg::CMD_ADD_TOKEN);
                        state_in = ST_CNT_RD;
                     end
                  end
                  jstgibbs_pkg::CMD_CLEAR: begin
                     clr_cnt_in = '0;
                     state_in   = ST_CLR;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_WP_RD: state_in = ST_WP_WR;
         ST_WP_WR: state_in = ST_DONE;
         ST_TP_RD: state_in = ST_TP_WR;
         ST_TP_WR: begin
            tps_in[cl_ff] = tps_ff[cl_ff] - jstgibbs_pkg::TPS_W'(tp_rd_ff) +
                            jstgibbs_pkg::TPS_W'(pv_ff);
            state_in = ST_DONE;
         end
         ST_CNT_RD: state_in = ST_CNT_WR;
         ST_CNT_WR: begin
            flag_in = flag_ff || cnt_flag;
            if (add_ff) begin
               state_in = ST_DONE;
            end else begin
               a_in     = '0;
               b_in     = '0;
               acc_in   = '0;
               state_in = ST_LBL_RD;
            end
         end
         ST_LBL_RD: state_in = ST_R3;
         ST_R3: begin
            ndl_in   = dl_rd_ff;
            state_in = ST_R3_W;
         end
         ST_R3_W: begin
            if (div_rsp.done) begin
               r3_in    = div_rsp.quot;
               state_in = ST_TOP_RD;
            end
         end
         ST_TOP_RD: state_in = ST_R1;
         ST_R1: begin
            r2num_in = DW'({dlt_rd_ff, {FW{1'b0}}}) + DW'(tp_rd_ff);
            r2den_in = DW'({ndl_ff, {FW{1'b0}}}) + DW'(tps_ff[a_ff]);
            state_in = ST_R1_W;
         end
         ST_R1_W: begin
            if (div_rsp.done) begin
               r1_in    = div_rsp.quot;
               state_in = ST_R2;
            end
         end
         ST_R2: state_in = ST_R2_W;
         ST_R2_W: begin
            if (div_rsp.done) begin
               r2_in    = div_rsp.quot;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_ACC;
         ST_ACC: begin
            acc_in = acc_sum[RWW] ? '1 : acc_sum[RWW-1:0];
            if (b_ff == TW'(jstgibbs_pkg::TOPICS - 1)) begin
               b_in = '0;
               if (a_ff == LW'(jstgibbs_pkg::LABELS - 1)) begin
                  state_in = ST_U;
               end else begin
                  a_in     = a_ff + LW'(1);
                  state_in = ST_LBL_RD;
               end
            end else begin
               b_in     = b_ff + TW'(1);
               state_in = ST_TOP_RD;
            end
         end
         ST_U: state_in = ST_U2;
         ST_U2: begin
            u_in     = prod_ff[jstgibbs_pkg::UNI_W +: RWW];
            a_in     = '0;
            b_in     = '0;
            state_in = ST_SCAN_RD;
         end
         ST_SCAN_RD: state_in = ST_SCAN_CMP;
         ST_SCAN_CMP: begin
            if (rw_rd_ff > u_ff) begin
               cl_in    = a_ff;
               ck_in    = b_ff;
               add_in   = 1'b1;
               state_in = ST_CNT_RD;
            end else if ((a_ff == LW'(jstgibbs_pkg::LABELS - 1)) &&
                         (b_ff == TW'(jstgibbs_pkg::TOPICS - 1))) begin
               cl_in    = LW'(jstgibbs_pkg::LABELS - 1);
               ck_in    = TW'(jstgibbs_pkg::TOPICS - 1);
               add_in   = 1'b1;
               state_in = ST_CNT_RD;
            end else begin
               if (b_ff == TW'(jstgibbs_pkg::TOPICS - 1)) begin
                  b_in = '0;
                  a_in = a_ff + LW'(1);
               end else begin
                  b_in = b_ff + TW'(1);
               end
               state_in = ST_SCAN_RD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_label_in  = cl_ff;
               rsp_topic_in  = ck_ff;
               rsp_status_in = flag_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         g_ff         <= jstgibbs_pkg::DOC_PRIOR_RESET;
         tps_ff       <= '{default: '0};
         add_ff       <= 1'b0;
         flag_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         g_ff         <= g_in;
         tps_ff       <= tps_in;
         add_ff       <= add_in;
         flag_ff      <= flag_in;
      end
      cmd_ff        <= cmd_in;
      d_ff          <= d_in;
      w_ff          <= w_in;
      pv_ff         <= pv_in;
      uni_ff        <= uni_in;
      cl_ff         <= cl_in;
      ck_ff         <= ck_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      acc_ff        <= acc_in;
      u_ff          <= u_in;
      ndl_ff        <= ndl_in;
      r1_ff         <= r1_in;
      r2_ff         <= r2_in;
      r3_ff         <= r3_in;
      r2num_ff      <= r2num_in;
      r2den_ff      <= r2den_in;
      prod_ff       <= prod_in;
      rsp_label_ff  <= rsp_label_in;
      rsp_topic_ff  <= rsp_topic_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

// ===== src/jstgibbs_div.sv =====
// iterative ratio divider: two quotient bits per cycle, result clamped at one
module jstgibbs_div (
   input  logic                      clock,
   input  logic                      reset,
   input  jstgibbs_pkg::div_req_type div_req,
   output jstgibbs_pkg::div_rsp_type div_rsp
);
   localparam int STEPS  = jstgibbs_pkg::Q_FRAC / 2;
   localparam int STEP_W = 4;
   localparam int DW     = jstgibbs_pkg::DIV_W;
   localparam int QW     = jstgibbs_pkg::Q_W;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DW-1:0]     rem_ff, rem_in;
   logic [DW-1:0]     den_ff, den_in;
   logic [QW-1:0]     q_ff, q_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [DW:0]       t1, t2, den_x;
   logic              b1, b2;

   always_comb begin
      den_x = {1'b0, den_ff};
      t1 = {rem_ff, 1'b0};
      b1 = (t1 >= den_x);
      if (b1) begin
         t1 = t1 - den_x;
      end
      t2 = {t1[DW-1:0], 1'b0};
      b2 = (t2 >= den_x);
      if (b2) begin
         t2 = t2 - den_x;
      end
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      if (div_req.start) begin
         if (div_req.den == '0) begin
            q_in    = '0;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else if (div_req.num >= div_req.den) begin
            q_in    = QW'(1) << jstgibbs_pkg::Q_FRAC;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            rem_in  = div_req.num;
            den_in  = div_req.den;
            q_in    = '0;
            cnt_in  = '0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = t2[DW-1:0];
         q_in   = {q_ff[QW-3:0], b1, b2};
         cnt_in = cnt_ff + STEP_W'(1);
         if (cnt_ff == STEP_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = q_ff;

endmodule

// ===== src/jstgibbs_checker.sv =====
// checker: port-level assertions of the sampler, bound to the top level
module jstgibbs_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [jstgibbs_pkg::LABEL_W-1:0] rsp_new_label,
   input logic [jstgibbs_pkg::TOPIC_W-1:0] rsp_new_topic,
   input logic                             rsp_status
);

   // clearing pass after reset, no stale item
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_ready))
      else $error("item or ready right after reset");

   // one item at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready in the cycle after an accepted item");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_new_label) &&
                                     $stable(rsp_new_topic) && $stable(rsp_status)))
      else $error("stalled result item changed");

endmodule

bind joint_sentiment_topic_gibbs_sampler jstgibbs_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_new_label (rsp_chan.new_label),
   .rsp_new_topic (rsp_chan.new_topic),
   .rsp_status    (rsp_chan.status)
);
